// File: src/sd_spi_command_block_engine_assert.svh
// Assertion macros for the SD SPI command engine.
// Used by the top level; no other dependencies.
`ifndef SD_SPI_COMMAND_BLOCK_ENGINE_ASSERT_SVH
`define SD_SPI_COMMAND_BLOCK_ENGINE_ASSERT_SVH
`define SDS_ASSERT_IMPL(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define SDS_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// File: src/sds_pkg.sv
// Package for the SD SPI command engine: phase codes, command codes, types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sds_pkg;
  localparam logic [2:0] CMD_SEND = 3'd0, CMD_RX = 3'd1, CMD_RBLK = 3'd2,
    CMD_WTOK = 3'd3, CMD_WDATA = 3'd4, CMD_DESEL = 3'd5;
  localparam logic [4:0] P_IDLE = 5'd0, P_SEL = 5'd1, P_PSEL = 5'd2, P_FRAME = 5'd3,
    P_POLL = 5'd4, P_EXTRA = 5'd5, P_TOK = 5'd6, P_RDATA = 5'd7, P_RCRC1 = 5'd8,
    P_RCRC2 = 5'd9, P_WTOK = 5'd10, P_WWAIT = 5'd11, P_WDATA = 5'd12,
    P_WLAST = 5'd13, P_WCRC1 = 5'd14, P_WCRC2 = 5'd15, P_WRESP = 5'd16,
    P_BUSY = 5'd17, P_REL = 5'd18;
  localparam logic [1:0] ST_OK = 2'd0, ST_TIMEOUT = 2'd1, ST_PREFACE = 2'd2,
    ST_REJECT = 2'd3;
  localparam logic [7:0] IDLE_BYTE = 8'hFF, STOP_TOKEN = 8'hFD;
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       chip_select;
    logic       data_valid;
    logic [7:0] data_out;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] response;
  } result_t;
endpackage
`default_nettype wire

// File: src/sds_out_reg.sv
// Output register with skid stage for result words.
// Depends on sds_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sds_out_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire sds_pkg::result_t in_word,
  output logic                  in_ready,
  output logic                  out_valid,
  output sds_pkg::result_t      out_word,
  input  wire logic             out_ready
);
  import sds_pkg::*;
  result_t skid;
  logic    skid_valid;
  assign in_ready = !skid_valid;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_valid && !out_ready) begin
        if (in_valid && in_ready) begin
          skid <= in_word;
          skid_valid <= 1'b1;
        end
      end else if (skid_valid) begin
        out_word <= skid;
        out_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
        if (in_valid) out_word <= in_word;
      end
    end
  end
endmodule
`default_nettype wire

// File: src/sd_spi_command_block_engine.sv
// SD SPI command engine: one input word per cycle while in_ready is high,
// result registered. Each accepted word updates the single phase register;
// a two-entry output skid keeps input ready while a result waits.
// Synchronous reset: idle, card released.
`timescale 1ns / 1ps
`default_nettype none
`include "sd_spi_command_block_engine_assert.svh"
module sd_spi_command_block_engine #(
  parameter int MAX_BLOCK_BYTES = 4096,
  parameter int RELEASE_CLOCK_BYTES = 10
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  cmd,
  input  wire logic [5:0]  cmd_index,
  input  wire logic        app_cmd,
  input  wire logic [31:0] argument,
  input  wire logic [7:0]  rx_byte,
  input  wire logic [12:0] block_length,
  input  wire logic [7:0]  token,
  input  wire logic [7:0]  data_byte,
  input  wire logic        data_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             tx_valid,
  output logic [7:0]       tx_byte,
  output logic             chip_select,
  output logic             data_valid,
  output logic [7:0]       data_out,
  output logic             done_res,
  output logic [1:0]       status,
  output logic [7:0]       response,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import sds_pkg::*;
  localparam int CW = $clog2(MAX_BLOCK_BYTES + 1) > 13 ? $clog2(MAX_BLOCK_BYTES + 1) : 13;
  localparam logic [CW-1:0] MAXB = CW'(MAX_BLOCK_BYTES);
  localparam logic [CW-1:0] RELB = CW'(RELEASE_CLOCK_BYTES);

  logic [7:0]    poll_limit;
  logic [15:0]   tok_limit;
  logic [4:0]    phase, phase_next;
  logic [CW-1:0] byte_counter, byte_counter_next;
  logic [15:0]   wait_counter, wait_counter_next;
  logic [31:0]   held_argument, held_argument_next;
  logic [5:0]    held_index, held_index_next;
  logic          preface_pending, preface_pending_next;
  logic          select_level, select_level_next;
  logic          emit;
  result_t       res, out_word;
  logic          acc;

  logic [5:0]  cidx;
  logic [31:0] carg;
  logic [7:0]  fb0;
  logic [7:0]  plim;
  logic [15:0] tlim;
  logic [CW-1:0] bc_inc;
  logic [CW-1:0] len_c;

  assign acc = in_valid && in_ready;
  assign cidx = preface_pending ? 6'd55 : held_index;
  assign carg = preface_pending ? 32'd0 : held_argument;
  assign fb0 = 8'h40 | {2'b00, cidx};
  assign plim = (poll_limit == 8'd0) ? 8'd1 : poll_limit;
  assign tlim = (tok_limit == 16'd0) ? 16'd1 : tok_limit;
  assign bc_inc = byte_counter + CW'(1);
  assign len_c = (CW'(block_length) > MAXB) ? MAXB : CW'(block_length);

  function automatic logic [7:0] frame_byte(input logic [CW-1:0] k, input logic [5:0] idx,
                                            input logic [31:0] arg);
    logic [7:0] b;
    b = 8'hFF;
    if (k == CW'(0)) b = 8'h40 | {2'b00, idx};
    else if (k == CW'(1)) b = arg[31:24];
    else if (k == CW'(2)) b = arg[23:16];
    else if (k == CW'(3)) b = arg[15:8];
    else if (k == CW'(4)) b = arg[7:0];
    else if (k == CW'(5)) b = (idx == 6'd0) ? 8'h95 : ((idx == 6'd8) ? 8'h87 : 8'h01);
    return b;
  endfunction

  task automatic put_tx(input logic [7:0] b);
    res.tx_valid = 1'b1;
    res.tx_byte = b;
  endtask

  always_comb begin
    phase_next = phase;
    byte_counter_next = byte_counter;
    wait_counter_next = wait_counter;
    held_argument_next = held_argument;
    held_index_next = held_index;
    preface_pending_next = preface_pending;
    select_level_next = select_level;
    emit = 1'b0;
    res = '0;
    if (cmd == CMD_DESEL) begin
      select_level_next = 1'b0;
      preface_pending_next = 1'b0;
      byte_counter_next = '0;
      wait_counter_next = 16'd0;
      phase_next = P_REL;
      emit = 1'b1;
      put_tx(IDLE_BYTE);
    end else if (phase == P_IDLE) begin
      if (cmd == CMD_SEND) begin
        held_index_next = cmd_index;
        preface_pending_next = app_cmd;
        held_argument_next = argument;
        phase_next = P_SEL;
        emit = 1'b1;
        put_tx(IDLE_BYTE);
      end else if (cmd == CMD_RBLK) begin
        byte_counter_next = len_c;
        wait_counter_next = 16'd1;
        phase_next = P_TOK;
        emit = 1'b1;
        put_tx(IDLE_BYTE);
      end else if (cmd == CMD_WTOK) begin
        held_argument_next = {24'd0, token};
        phase_next = P_WTOK;
        emit = 1'b1;
        put_tx(token);
      end
    end else if (phase == P_WWAIT) begin
      if (cmd == CMD_WDATA) begin
        byte_counter_next = bc_inc;
        phase_next = (data_last || bc_inc >= MAXB) ? P_WLAST : P_WDATA;
        emit = 1'b1;
        put_tx(data_byte);
      end
    end else if (cmd == CMD_RX) begin
      emit = 1'b1;
      unique case (phase)
        P_SEL: begin
          select_level_next = 1'b1;
          if (preface_pending) begin
            phase_next = P_PSEL;
            put_tx(IDLE_BYTE);
          end else begin
            byte_counter_next = '0;
            phase_next = P_FRAME;
            put_tx(fb0);
          end
        end
        P_PSEL: begin
          byte_counter_next = '0;
          phase_next = P_FRAME;
          put_tx(fb0);
        end
        P_FRAME: begin
          byte_counter_next = bc_inc;
          if (bc_inc < ((cidx == 6'd12) ? CW'(7) : CW'(6))) begin
            put_tx(frame_byte(bc_inc, cidx, carg));
          end else begin
            wait_counter_next = 16'd1;
            phase_next = P_POLL;
            put_tx(IDLE_BYTE);
          end
        end
        P_POLL: begin
          if (rx_byte != IDLE_BYTE) begin
            if (preface_pending) begin
              preface_pending_next = 1'b0;
              if (rx_byte > 8'd1) begin
                phase_next = P_IDLE;
                res.done_res = 1'b1;
                res.status = ST_PREFACE;
                res.response = rx_byte;
              end else begin
                byte_counter_next = '0;
                phase_next = P_FRAME;
                put_tx(8'h40 | {2'b00, held_index});
              end
            end else if (held_index == 6'd24 || held_index == 6'd25) begin
              held_argument_next = {24'd0, rx_byte};
              phase_next = P_EXTRA;
              put_tx(IDLE_BYTE);
            end else begin
              phase_next = P_IDLE;
              res.done_res = 1'b1;
              res.status = ST_OK;
              res.response = rx_byte;
            end
          end else if (wait_counter >= {8'd0, plim}) begin
            preface_pending_next = 1'b0;
            phase_next = P_IDLE;
            res.done_res = 1'b1;
            res.status = ST_TIMEOUT;
            res.response = IDLE_BYTE;
          end else begin
            wait_counter_next = wait_counter + 16'd1;
            put_tx(IDLE_BYTE);
          end
        end
        P_EXTRA: begin
          phase_next = P_IDLE;
          res.done_res = 1'b1;
          res.status = ST_OK;
          res.response = held_argument[7:0];
        end
        P_TOK: begin
          if (rx_byte != IDLE_BYTE) begin
            phase_next = (byte_counter != '0) ? P_RDATA : P_RCRC1;
          end else if (wait_counter >= tlim) begin
            select_level_next = 1'b0;
            preface_pending_next = 1'b0;
            byte_counter_next = '0;
            wait_counter_next = 16'd1;
            phase_next = P_REL;
          end else begin
            wait_counter_next = wait_counter + 16'd1;
          end
          put_tx(IDLE_BYTE);
        end
        P_RDATA: begin
          byte_counter_next = byte_counter - CW'(1);
          if (byte_counter == CW'(1)) phase_next = P_RCRC1;
          put_tx(IDLE_BYTE);
          res.data_valid = 1'b1;
          res.data_out = rx_byte;
        end
        P_RCRC1: begin
          phase_next = P_RCRC2;
          put_tx(IDLE_BYTE);
        end
        P_RCRC2: begin
          phase_next = P_IDLE;
          res.done_res = 1'b1;
        end
        P_WTOK: begin
          if (held_argument[7:0] == STOP_TOKEN) begin
            phase_next = P_BUSY;
            put_tx(IDLE_BYTE);
          end else begin
            byte_counter_next = '0;
            phase_next = P_WWAIT;
            emit = 1'b0;
          end
        end
        P_WDATA: begin
          phase_next = P_WWAIT;
          emit = 1'b0;
        end
        P_WLAST: begin
          phase_next = P_WCRC1;
          put_tx(IDLE_BYTE);
        end
        P_WCRC1: begin
          phase_next = P_WCRC2;
          put_tx(IDLE_BYTE);
        end
        P_WCRC2: begin
          phase_next = P_WRESP;
          put_tx(IDLE_BYTE);
        end
        P_WRESP: begin
          if (rx_byte[4:0] != 5'h05) begin
            phase_next = P_IDLE;
            res.done_res = 1'b1;
            res.status = ST_REJECT;
          end else begin
            phase_next = P_BUSY;
            put_tx(IDLE_BYTE);
          end
        end
        P_BUSY: begin
          if (rx_byte == IDLE_BYTE) begin
            phase_next = P_IDLE;
            res.done_res = 1'b1;
          end else begin
            put_tx(IDLE_BYTE);
          end
        end
        P_REL: begin
          byte_counter_next = bc_inc;
          if (bc_inc < RELB) begin
            put_tx(IDLE_BYTE);
          end else begin
            phase_next = P_IDLE;
            res.done_res = 1'b1;
            res.status = wait_counter[1:0];
            wait_counter_next = 16'd0;
          end
        end
        default: begin
          phase_next = P_IDLE;
          emit = 1'b0;
        end
      endcase
    end
    res.chip_select = select_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_limit <= 8'd8;
      tok_limit <= 16'd10000;
      phase <= P_IDLE;
      byte_counter <= '0;
      wait_counter <= 16'd0;
      held_argument <= 32'd0;
      held_index <= 6'd0;
      preface_pending <= 1'b0;
      select_level <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == 1'b0) poll_limit <= cfg_data[7:0];
        else tok_limit <= cfg_data;
      end
      if (acc) begin
        phase <= phase_next;
        byte_counter <= byte_counter_next;
        wait_counter <= wait_counter_next;
        held_argument <= held_argument_next;
        held_index <= held_index_next;
        preface_pending <= preface_pending_next;
        select_level <= select_level_next;
      end
    end
  end

  sds_out_reg u_out (
    .clk(clk), .rst(rst), .in_valid(acc && emit), .in_word(res), .in_ready(in_ready),
    .out_valid(out_valid), .out_word(out_word), .out_ready(out_ready)
  );

  assign tx_valid = out_word.tx_valid;
  assign tx_byte = out_word.tx_byte;
  assign chip_select = out_word.chip_select;
  assign data_valid = out_word.data_valid;
  assign data_out = out_word.data_out;
  assign done_res = out_word.done_res;
  assign status = out_word.status;
  assign response = out_word.response;

  `SDS_ASSERT_IMPL(a_done_no_tx, out_valid && done_res, !tx_valid)
  `SDS_ASSERT_NEXT(a_desel_rel, acc && cmd == CMD_DESEL, phase == P_REL && !select_level)
  `SDS_ASSERT_IMPL(a_data_in_rdata, out_valid && data_valid, tx_valid)
endmodule
`default_nettype wire
